### hw/rtl/ltd_pkg.sv
// Shared constants, types and register codes for the load-cell tare and deadband core.
package ltd_pkg;

  localparam int unsigned CAL_SAMPLES  = 10;
  localparam int unsigned TARE_SAMPLES = 5;

  localparam int unsigned RAW_W   = 24;
  localparam int unsigned MG_W    = 26;
  localparam int unsigned DB_W    = 16;
  localparam int unsigned GAIN_W  = 24;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned MULT_W  = RAW_W + GAIN_W;
  localparam int unsigned MGF_W   = MULT_W - FRAC_W;

  // averaging: up to 16 samples of 24 bits
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned SUM_W   = RAW_W + 4;
  localparam int unsigned MAG_W   = SUM_W;

  // truncating divide by a small constant through a scaled reciprocal
  localparam int unsigned RECIP_SHIFT = 32;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned PROD_W      = MAG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] CAL_RECIP = RECIP_W'(
      ((64'd1 << RECIP_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
  localparam logic [RECIP_W-1:0] TARE_RECIP = RECIP_W'(
      ((64'd1 << RECIP_SHIFT) + 64'(TARE_SAMPLES) - 64'd1) / 64'(TARE_SAMPLES));

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 26;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADBAND   = 2'd0,
    CFG_GAIN       = 2'd1,
    CFG_ZERO_LIMIT = 2'd2,
    CFG_CHANGE_THR = 2'd3
  } cfg_idx_e;

  localparam logic [DB_W-1:0]   DEADBAND_RST   = DB_W'(1500);
  localparam logic [GAIN_W-1:0] GAIN_RST       = GAIN_W'(157163);
  localparam logic [MG_W-1:0]   ZERO_LIMIT_RST = MG_W'(2000);
  localparam logic [THR_W-1:0]  CHANGE_THR_RST = THR_W'(100);

  typedef struct packed {
    logic [DB_W-1:0]   deadband;
    logic [GAIN_W-1:0] gain;
    logic [MG_W-1:0]   zero_limit;
    logic [THR_W-1:0]  change_thr;
  } cfg_t;

  // weight item handed from the offset stage to the weighing pipeline
  typedef struct packed {
    logic             valid;
    logic [RAW_W-1:0] diff;
    logic             tare_done;
  } weigh_req_t;

  typedef enum logic [4:0] {
    PH_CAL     = 5'b00001,
    PH_TARE    = 5'b00010,
    PH_WEIGH   = 5'b00100,
    PH_DIV_MUL = 5'b01000,
    PH_DIV_FIX = 5'b10000
  } phase_e;

endpackage

### hw/rtl/ltd_if.sv
// Valid/ready channel interfaces for samples in and weight results out.
interface ltd_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [ltd_pkg::RAW_W-1:0]    raw_sample;
  logic                                tare_request;

  modport source (output valid, raw_sample, tare_request, input ready);
  modport sink   (input valid, raw_sample, tare_request, output ready);
endinterface

interface ltd_result_if;
  logic                       valid;
  logic                       ready;
  logic [ltd_pkg::MG_W-1:0]   weight_mg;
  logic                       tare_done;
  logic                       above_zero;
  logic                       display_changed;

  modport source (output valid, weight_mg, tare_done, above_zero, display_changed,
                  input ready);
  modport sink   (input valid, weight_mg, tare_done, above_zero, display_changed,
                  output ready);
endinterface

### hw/rtl/ltd_offset.sv
// Input register, calibration/tare averaging, offset divide and deadband check.
module ltd_offset (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  ltd_sample_if.sink                sample_i,
  input  logic                      adv_en_i,
  input  logic [ltd_pkg::DB_W-1:0]  deadband_i,
  output ltd_pkg::weigh_req_t       req_o
);
  import ltd_pkg::*;

  phase_e              phase_q, phase_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [RAW_W-1:0]    offset_q, offset_d;
  logic                pending_q, pending_d;
  logic                div_tare_q, div_tare_d;
  logic                div_neg_q;
  logic [RAW_W-1:0]    div_quot_q;

  logic                s1_valid_q;
  logic [RAW_W-1:0]    s1_raw_q;
  logic                s1_req_q;

  logic                dividing, in_ready, accept, s1_adv;
  logic [SUM_W-1:0]    raw_ext, sum_acc;
  logic [CNT_W-1:0]    cnt_inc, need;
  logic [MAG_W-1:0]    sum_mag;
  logic [RECIP_W-1:0]  recip;
  logic [PROD_W-1:0]   prod;
  logic [RAW_W:0]      diff;
  logic                nz;

  assign dividing = (phase_q == PH_DIV_MUL) || (phase_q == PH_DIV_FIX);
  assign in_ready = !dividing && (!s1_valid_q || adv_en_i);
  assign accept   = sample_i.valid && in_ready;
  assign s1_adv   = s1_valid_q && adv_en_i && !dividing;
  assign sample_i.ready = in_ready;

  assign raw_ext = {{(SUM_W-RAW_W){s1_raw_q[RAW_W-1]}}, s1_raw_q};
  assign sum_acc = sum_q + raw_ext;
  assign cnt_inc = cnt_q + CNT_W'(1);
  assign need    = (phase_q == PH_TARE) ? CNT_W'(TARE_SAMPLES) : CNT_W'(CAL_SAMPLES);

  // magnitude times reciprocal, sign put back afterwards: truncation toward zero
  assign sum_mag = sum_q[SUM_W-1] ? (MAG_W'(0) - sum_q) : sum_q;
  assign recip   = div_tare_q ? TARE_RECIP : CAL_RECIP;
  assign prod    = PROD_W'(sum_mag) * PROD_W'(recip);

  assign diff = {s1_raw_q[RAW_W-1], s1_raw_q} - {offset_q[RAW_W-1], offset_q};
  assign nz   = !diff[RAW_W] && (diff[RAW_W-1:0] != '0) &&
                (diff[RAW_W-1:0] >= RAW_W'(deadband_i));

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    sum_d      = sum_q;
    offset_d   = offset_q;
    pending_d  = pending_q;
    div_tare_d = div_tare_q;
    req_o      = '0;
    unique case (phase_q)
      PH_CAL, PH_TARE: begin
        // tare requests are ignored while averaging
        if (s1_adv) begin
          sum_d = sum_acc;
          cnt_d = cnt_inc;
          if (cnt_inc == need) begin
            phase_d    = PH_DIV_MUL;
            div_tare_d = (phase_q == PH_TARE);
            cnt_d      = '0;
          end
        end
      end
      PH_WEIGH: begin
        if (s1_adv) begin
          if (s1_req_q) begin
            if (TARE_SAMPLES == 1) begin
              offset_d  = s1_raw_q;
              pending_d = 1'b1;
            end else begin
              phase_d = PH_TARE;
              sum_d   = raw_ext;
              cnt_d   = CNT_W'(1);
            end
          end else begin
            req_o.valid     = 1'b1;
            req_o.diff      = nz ? diff[RAW_W-1:0] : '0;
            req_o.tare_done = pending_q;
            pending_d       = 1'b0;
          end
        end
      end
      PH_DIV_MUL: begin
        phase_d = PH_DIV_FIX;
      end
      PH_DIV_FIX: begin
        offset_d  = div_neg_q ? (RAW_W'(0) - div_quot_q) : div_quot_q;
        pending_d = pending_q | div_tare_q;
        sum_d     = '0;
        phase_d   = PH_WEIGH;
      end
      default: begin
        phase_d = PH_CAL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_CAL;
      cnt_q      <= '0;
      sum_q      <= '0;
      offset_q   <= '0;
      pending_q  <= 1'b0;
      div_tare_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      sum_q      <= sum_d;
      offset_q   <= offset_d;
      pending_q  <= pending_d;
      div_tare_q <= div_tare_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_raw_q <= sample_i.raw_sample;
      s1_req_q <= sample_i.tare_request;
    end
    if (phase_q == PH_DIV_MUL) begin
      div_quot_q <= prod[RECIP_SHIFT +: RAW_W];
      div_neg_q  <= sum_q[SUM_W-1];
    end
  end

endmodule

### hw/rtl/ltd_weigh.sv
// Gain multiply, saturation, zero limit and display-change tracking with result register.
module ltd_weigh (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ltd_pkg::weigh_req_t  req_i,
  input  ltd_pkg::cfg_t        cfg_i,
  ltd_result_if.source         result_o,
  output logic                 adv_en_o
);
  import ltd_pkg::*;

  logic               pe;
  logic               s2_valid_q;
  logic [RAW_W-1:0]   s2_diff_q;
  logic               s2_tare_q;
  logic               s3_valid_q;
  logic [MGF_W-1:0]   s3_mg_q;
  logic               s3_tare_q;
  logic               out_valid_q;
  logic [MG_W-1:0]    out_mg_q;
  logic               out_tare_q, out_above_q, out_changed_q;
  logic [MG_W-1:0]    last_q;
  logic               have_q;

  logic [MULT_W-1:0]  mult;
  logic               sat;
  logic [MG_W-1:0]    mg, w, gap;
  logic               above, changed;

  assign pe       = !out_valid_q || result_o.ready;
  assign adv_en_o = pe;

  assign mult = MULT_W'(s2_diff_q) * MULT_W'(cfg_i.gain);

  assign sat     = |s3_mg_q[MGF_W-1:MG_W];
  assign mg      = sat ? '1 : s3_mg_q[MG_W-1:0];
  assign above   = mg >= cfg_i.zero_limit;
  assign w       = above ? mg : '0;
  assign gap     = (w > last_q) ? (w - last_q) : (last_q - w);
  assign changed = !have_q || (gap > MG_W'(cfg_i.change_thr));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_q      <= '0;
      have_q      <= 1'b0;
    end else if (pe) begin
      s2_valid_q  <= req_i.valid;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
      if (s3_valid_q && changed) begin
        last_q <= w;
        have_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pe) begin
      s2_diff_q     <= req_i.diff;
      s2_tare_q     <= req_i.tare_done;
      s3_mg_q       <= mult[FRAC_W +: MGF_W];
      s3_tare_q     <= s2_tare_q;
      out_mg_q      <= w;
      out_tare_q    <= s3_tare_q;
      out_above_q   <= above;
      out_changed_q <= changed;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.weight_mg       = out_mg_q;
  assign result_o.tare_done       = out_tare_q;
  assign result_o.above_zero      = out_above_q;
  assign result_o.display_changed = out_changed_q;

endmodule

### hw/rtl/load_cell_tare_deadband_core.sv
// Load-cell tare and deadband core: top level with configuration registers.
// A sample is registered at the input, then in the diff, weight and result registers.
// Throughput: one sample per cycle while results are taken; after the last averaging
// sample ready is low while the offset is divided (reciprocal multiply, then sign fix).
// Reset: registers to their defaults, offset zero, calibration over the first samples.
module load_cell_tare_deadband_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  ltd_sample_if.sink                       sample_i,
  ltd_result_if.source                     result_o,
  input  logic                             cfg_we_i,
  input  logic [ltd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ltd_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import ltd_pkg::*;

  cfg_t        cfg_q;
  weigh_req_t  req;
  logic        adv_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadband   <= DEADBAND_RST;
      cfg_q.gain       <= GAIN_RST;
      cfg_q.zero_limit <= ZERO_LIMIT_RST;
      cfg_q.change_thr <= CHANGE_THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEADBAND:   cfg_q.deadband   <= cfg_wdata_i[DB_W-1:0];
        CFG_GAIN:       cfg_q.gain       <= cfg_wdata_i[GAIN_W-1:0];
        CFG_ZERO_LIMIT: cfg_q.zero_limit <= cfg_wdata_i[MG_W-1:0];
        CFG_CHANGE_THR: cfg_q.change_thr <= cfg_wdata_i[THR_W-1:0];
      endcase
    end
  end

  ltd_offset u_offset (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (sample_i),
    .adv_en_i   (adv_en),
    .deadband_i (cfg_q.deadband),
    .req_o      (req)
  );

  ltd_weigh u_weigh (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .cfg_i    (cfg_q),
    .result_o (result_o),
    .adv_en_o (adv_en)
  );

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the load-cell tare and deadband core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ltd_pkg::*;

  localparam int unsigned QUIET_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam longint      WEIGHT_MAX   = (longint'(1) << MG_W) - 1;

  typedef struct packed {
    logic [MG_W-1:0] weight_mg;
    logic            tare_done;
    logic            above_zero;
    logic            display_changed;
  } weight_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  ltd_sample_if sample_ch ();
  ltd_result_if result_ch ();

  load_cell_tare_deadband_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_ch),
    .result_o    (result_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // mirror of the block: register values and offset averaging state
  cfg_t       live_regs;
  phase_e     avg_phase;
  int unsigned avg_count;
  longint     avg_total;
  longint     offset_counts;
  bit         tare_finished;
  logic [MG_W-1:0] shown_mg;
  bit         shown_any;

  weight_result_t expected_weights[$];

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned errors;
  int unsigned samples_sent;
  int unsigned weights_checked;
  int unsigned tares_sent;
  int unsigned settings_used;
  int unsigned cycle_count;
  longint      tare_level;

  function automatic bit predict_weight(input logic signed [RAW_W-1:0] raw, input logic tare,
                                        output weight_result_t res_item);
    int unsigned need;
    longint d;
    longint band;
    longint mg;
    bit above;
    logic [MG_W-1:0] w;
    logic [MG_W-1:0] diff;
    res_item = '0;
    if (avg_phase != PH_WEIGH) begin
      need = (avg_phase == PH_CAL) ? CAL_SAMPLES : TARE_SAMPLES;
      avg_total += longint'(raw);
      avg_count++;
      if (avg_count >= need) begin
        offset_counts = avg_total / longint'(need);
        if (avg_phase == PH_TARE) tare_finished = 1'b1;
        avg_phase = PH_WEIGH;
        avg_count = 0;
        avg_total = 0;
      end
      return 1'b0;
    end
    if (tare) begin
      if (TARE_SAMPLES <= 1) begin
        offset_counts = longint'(raw);
        tare_finished = 1'b1;
      end else begin
        avg_phase = PH_TARE;
        avg_total = longint'(raw);
        avg_count = 1;
      end
      return 1'b0;
    end
    d = longint'(raw) - offset_counts;
    band = longint'(live_regs.deadband);
    mg = 0;
    if (!(d > -band && d < band) && d > 0) begin
      mg = (d * longint'(live_regs.gain)) >>> FRAC_W;
      if (mg > WEIGHT_MAX) mg = WEIGHT_MAX;
    end
    above = mg >= longint'(live_regs.zero_limit);
    w = above ? MG_W'(mg) : '0;
    diff = (w > shown_mg) ? w - shown_mg : shown_mg - w;
    res_item.weight_mg       = w;
    res_item.tare_done       = tare_finished;
    res_item.above_zero      = above;
    res_item.display_changed = !shown_any || diff > MG_W'(live_regs.change_thr);
    if (res_item.display_changed) begin
      shown_mg = w;
      shown_any = 1'b1;
    end
    tare_finished = 1'b0;
    return 1'b1;
  endfunction

  // valid is left high after a transaction; the next call or wait_quiet decides
  task automatic send_sample(input logic signed [RAW_W-1:0] raw, input logic tare);
    weight_result_t w;
    while ($urandom_range(99, 0) < idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_ch.valid        <= 1'b1;
    sample_ch.raw_sample   <= raw;
    sample_ch.tare_request <= tare;
    @(posedge clk_i);
    while (!sample_ch.ready) @(posedge clk_i);
    samples_sent++;
    if (tare) tares_sent++;
    if (predict_weight(raw, tare, w)) expected_weights.push_back(w);
  endtask

  task automatic wait_quiet();
    sample_ch.valid <= 1'b0;
    while (expected_weights.size() != 0) @(posedge clk_i);
    // averaging samples give no result but may still be in the divider
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_DEADBAND:   live_regs.deadband   = data[DB_W-1:0];
      CFG_GAIN:       live_regs.gain       = data[GAIN_W-1:0];
      CFG_ZERO_LIMIT: live_regs.zero_limit = data[MG_W-1:0];
      CFG_CHANGE_THR: live_regs.change_thr = data[THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] db, gain, zl, thr);
    wait_quiet();
    write_reg(CFG_DEADBAND, db);
    write_reg(CFG_GAIN, gain);
    write_reg(CFG_ZERO_LIMIT, zl);
    write_reg(CFG_CHANGE_THR, thr);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  function automatic logic signed [RAW_W-1:0] pick_raw();
    longint edge_off;
    edge_off = longint'(live_regs.deadband) - 1 + longint'($urandom_range(3, 0));
    case ($urandom_range(9, 0))
      0, 1, 2, 3: return RAW_W'(offset_counts + longint'($urandom_range(8191, 0)) - 4096);
      4, 5:       return RAW_W'($urandom_range(1, 0) ? offset_counts + edge_off
                                                     : offset_counts - edge_off);
      6:          return RAW_W'(offset_counts + longint'($urandom_range(1 << 20, 0)));
      7:          return RAW_W'($urandom);
      8:          return $urandom_range(1, 0) ? RAW_W'(8388607) : RAW_W'(-8388608);
      default:    return RAW_W'(offset_counts + 4 * longint'($urandom_range(65535, 0)));
    endcase
  endfunction

  task automatic report_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    weight_result_t exp_w;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (expected_weights.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual weight_mg=%0d", $time,
                 result_ch.weight_mg);
        errors++;
      end else begin
        exp_w = expected_weights.pop_front();
        weights_checked++;
        report_field("weight_mg", exp_w.weight_mg, result_ch.weight_mg);
        report_field("tare_done", exp_w.tare_done, result_ch.tare_done);
        report_field("above_zero", exp_w.above_zero, result_ch.above_zero);
        report_field("display_changed", exp_w.display_changed, result_ch.display_changed);
      end
    end
  end

  always @(posedge clk_i) begin
    result_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, expected_weights.size());
      $display("simulation failed");
      $finish;
    end
  end

  // offset comes out as -13/10, truncated toward zero; a tare request here is ignored
  task automatic test_calibration();
    send_sample(-24'sd8388608, 1'b0);
    send_sample(24'sd8388607, 1'b1);
    send_sample(-24'sd3, 1'b0);
    send_sample(-24'sd1, 1'b0);
    send_sample(24'sd5, 1'b0);
    send_sample(24'sd0, 1'b1);
    send_sample(-24'sd2, 1'b0);
    send_sample(-24'sd8, 1'b0);
    send_sample(24'sd1, 1'b0);
    send_sample(-24'sd4, 1'b0);
  endtask

  // reset registers: both sides of the deadband edge and a negative difference
  task automatic test_weigh_defaults();
    send_sample(RAW_W'(offset_counts), 1'b0);
    send_sample(RAW_W'(offset_counts + 1499), 1'b0);
    send_sample(RAW_W'(offset_counts + 1500), 1'b0);
    send_sample(RAW_W'(offset_counts - 1500), 1'b0);
  endtask

  task automatic test_tare();
    send_sample(24'sd1000, 1'b1);
    send_sample(24'sd1010, 1'b1);
    send_sample(24'sd990, 1'b0);
    send_sample(24'sd1003, 1'b0);
    send_sample(-24'sd7, 1'b0);
    send_sample(RAW_W'(offset_counts + 3000), 1'b0);
  endtask

  // one mg per count, no band, no zero limit: threshold edge at exactly 100
  task automatic test_unity_gain();
    program_regs(26'd0, 26'd65536, 26'd0, 26'd100);
    send_sample(RAW_W'(offset_counts), 1'b0);
    send_sample(RAW_W'(offset_counts + 100), 1'b0);
    send_sample(RAW_W'(offset_counts + 101), 1'b0);
    send_sample(RAW_W'(offset_counts - 1), 1'b0);
    send_sample(RAW_W'(offset_counts + 1), 1'b0);
  endtask

  // all-ones writes are masked to each register width; saturation at full scale
  task automatic test_register_extremes();
    program_regs('1, '1, 26'd0, '1);
    send_sample(24'sd8388607, 1'b0);
    send_sample(-24'sd8388608, 1'b0);
    program_regs(26'd0, 26'd0, '1, 26'd0);
    send_sample(24'sd8388607, 1'b0);
  endtask

  task automatic run_random_phase(input int unsigned count, src_pct, snk_pct,
                                  input logic [CFG_DATA_W-1:0] db, gain, zl, thr);
    logic signed [RAW_W-1:0] raw;
    logic tare;
    program_regs(db, gain, zl, thr);
    idle_pct  = src_pct;
    stall_pct = snk_pct;
    repeat (count) begin
      if (avg_phase == PH_TARE)
        raw = RAW_W'(tare_level + longint'($urandom_range(63, 0)) - 32);
      else
        raw = pick_raw();
      tare = ($urandom_range(99, 0) < 3);
      if (tare && avg_phase == PH_WEIGH) tare_level = longint'(raw);
      send_sample(raw, tare);
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(370, 0, 0, 26'd1500, 26'd157163, 26'd2000, 26'd100);
    run_random_phase(370, 79, 0, 26'd0, 26'd65536, 26'd0, 26'd0);
    run_random_phase(370, 0, 79, 26'd65535, 26'd16777215, 26'd67108863, 26'd65535);
    run_random_phase(370, 22, 22, CFG_DATA_W'($urandom_range(4000, 0)),
                     CFG_DATA_W'($urandom_range(1 << 20, 1)),
                     CFG_DATA_W'($urandom_range(20000, 0)),
                     CFG_DATA_W'($urandom_range(500, 0)));
    run_random_phase(370, 0, 0, 26'd40, 26'd1048576, 26'd500, 26'd30);
  endtask

  initial begin
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = CFG_DEADBAND;
    cfg_wdata_i            = '0;
    sample_ch.valid        = 1'b0;
    sample_ch.raw_sample   = '0;
    sample_ch.tare_request = 1'b0;
    result_ch.ready        = 1'b0;
    idle_pct               = 0;
    stall_pct              = 0;
    live_regs     = '{deadband: DEADBAND_RST, gain: GAIN_RST,
                      zero_limit: ZERO_LIMIT_RST, change_thr: CHANGE_THR_RST};
    avg_phase     = PH_CAL;
    avg_count     = 0;
    avg_total     = 0;
    offset_counts = 0;
    tare_finished = 1'b0;
    shown_mg      = '0;
    shown_any     = 1'b0;
    tare_level    = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_calibration();
    test_weigh_defaults();
    test_tare();
    test_unity_gain();
    test_register_extremes();
    test_random_traffic();
    wait_quiet();

    $display("Covered %0d samples (%0d with tare request), %0d weight results checked,",
             samples_sent, tares_sent, weights_checked);
    $display("over %0d register settings with source/sink idling from none to 79 percent.",
             settings_used);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### sim.f
hw/rtl/ltd_pkg.sv
hw/rtl/ltd_if.sv
hw/rtl/ltd_offset.sv
hw/rtl/ltd_weigh.sv
hw/rtl/load_cell_tare_deadband_core.sv
tb/sv/testbench.sv
